/* src/bmq_pkg.sv */
// shared types and constants of the blocking message queue
`default_nettype none

package bmq_pkg;

  // fixed field widths
  localparam int TASK_W   = 4;
  localparam int DATA_W   = 32;
  localparam int CAP_W    = 5;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;

  // request type codes
  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_RECV = 1'b1;

  // result kind codes
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_WAKE  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] STS_WAIT = 2'd2;

  // waiter kind codes
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RECV = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT2
  } bmq_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic commit;
    logic load2;
  } bmq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic two;
  } bmq_sts_t;

endpackage

`default_nettype wire

/* src/bmq_req_if.sv */
// request channel: valid/ready handshake with the request word
`default_nettype none

interface bmq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [bmq_pkg::TASK_W-1:0] task_id;
  logic [bmq_pkg::DATA_W-1:0] message;
  logic                       may_wait;

  modport source (output valid, output req_type, output task_id, output message,
                  output may_wait, input ready);
  modport sink   (input valid, input req_type, input task_id, input message,
                  input may_wait, output ready);
endinterface

`default_nettype wire

/* src/bmq_rsp_if.sv */
// result channel: valid/ready handshake with the result word
`default_nettype none

interface bmq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         reply_kind;
  logic [bmq_pkg::TASK_W-1:0]   target_task;
  logic [bmq_pkg::STATUS_W-1:0] status;
  logic [bmq_pkg::DATA_W-1:0]   data_word;
  logic                         last;

  modport source (output valid, output reply_kind, output target_task, output status,
                  output data_word, output last, input ready);
  modport sink   (input valid, input reply_kind, input target_task, input status,
                  input data_word, input last, output ready);
endinterface

`default_nettype wire

/* src/bmq_ctrl.sv */
// controller state machine of the blocking message queue
`default_nettype none

module bmq_ctrl (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic               in_ready,
  input  bmq_pkg::bmq_sts_t  sts,
  output bmq_pkg::bmq_cmd_t  cmd
);

  bmq_pkg::bmq_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      bmq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = bmq_pkg::ST_EXEC;
        end
      end
      bmq_pkg::ST_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = sts.two ? bmq_pkg::ST_EMIT2 : bmq_pkg::ST_IDLE;
        end
      end
      bmq_pkg::ST_EMIT2: begin
        if (sts.out_free) begin
          cmd.load2 = 1'b1;
          state_nxt = bmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bmq_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a request with a wake-up always goes on to deliver its reply
  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmq_pkg::ST_EXEC && sts.out_free && sts.two)
      |=> (state_r == bmq_pkg::ST_EMIT2))
    else $error("second result not scheduled");
`endif

endmodule

`default_nettype wire

/* src/bmq_dpath.sv */
// datapath: ring and waiter memories, pointers, decision logic, result register
`default_nettype none

module bmq_dpath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_TASKS   = 16,
  parameter int MSG_WIDTH   = 32
) (
  input  wire  logic                               clk,
  input  wire  logic                               rst_n,
  input  bmq_pkg::bmq_cmd_t                        cmd,
  output bmq_pkg::bmq_sts_t                        sts,
  input  wire  logic                               in_req_type,
  input  wire  logic [bmq_pkg::TASK_W-1:0]         in_task_id,
  input  wire  logic [bmq_pkg::DATA_W-1:0]         in_message,
  input  wire  logic                               in_may_wait,
  input  wire  logic                               cfg_we,
  input  wire  logic [bmq_pkg::CAP_W-1:0]          cfg_wdata,
  input  wire  logic                               out_ready,
  output logic                                     out_valid,
  output logic                                     out_reply_kind,
  output logic [bmq_pkg::TASK_W-1:0]               out_target_task,
  output logic [bmq_pkg::STATUS_W-1:0]             out_status,
  output logic [bmq_pkg::DATA_W-1:0]               out_data_word,
  output logic                                     out_last
);

  // stored word width, ring slots reachable by a 5-bit capacity
  localparam int SW         = (MSG_WIDTH < bmq_pkg::DATA_W) ? MSG_WIDTH : bmq_pkg::DATA_W;
  localparam int RING_DEPTH = (QUEUE_DEPTH < 31) ? QUEUE_DEPTH : 31;
  localparam int RIW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int WIW        = $clog2(MAX_TASKS);
  localparam int WCW        = $clog2(MAX_TASKS + 1);
  localparam int CAP_RST    = (QUEUE_DEPTH < 16) ? QUEUE_DEPTH : 16;
  localparam logic [bmq_pkg::CAP_W-1:0] CAP_MAX  = bmq_pkg::CAP_W'(RING_DEPTH);
  localparam logic [bmq_pkg::CAP_W-1:0] CAP_INIT = bmq_pkg::CAP_W'(CAP_RST);

  // memories
  logic [SW-1:0]              ring_mem [RING_DEPTH];
  logic [bmq_pkg::TASK_W-1:0] wfifo_mem [MAX_TASKS];
  logic [SW-1:0]              pend_mem [MAX_TASKS];

  // control state
  logic [RIW-1:0]                 widx_r, widx_nxt, ridx_r, ridx_nxt;
  logic [bmq_pkg::CAP_W-1:0]      fill_r, fill_nxt, cap_r, cap_nxt;
  logic [bmq_pkg::MODE_W-1:0]     mode_r, mode_nxt;
  logic [WIW-1:0]                 whead_r, whead_nxt;
  logic [WCW-1:0]                 wcount_r, wcount_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // request latch and registered memory reads
  logic                           req_type_r;
  logic [bmq_pkg::TASK_W-1:0]     task_r;
  logic [SW-1:0]                  msg_r;
  logic                           may_wait_r;
  logic [SW-1:0]                  ring_rd_r;
  logic [SW-1:0]                  pend_rd_r;
  logic [bmq_pkg::TASK_W-1:0]     wtask_rd_r;

  // result register
  logic                           out_kind_r;
  logic [bmq_pkg::TASK_W-1:0]     out_task_r;
  logic [bmq_pkg::STATUS_W-1:0]   out_status_r;
  logic [bmq_pkg::DATA_W-1:0]     out_data_r;
  logic                           out_last_r;

  // decision
  logic                           is_recv, has_recv, has_send, ring_full, ring_empty;
  logic                           wl_full, do_pop, do_ring_rd, do_ring_wr, try_wait;
  logic                           do_push, send_store;
  logic [SW-1:0]                  ring_wdata;
  logic [bmq_pkg::CAP_W-1:0]      widx_inc, ridx_inc, cfg_cap;
  logic [WCW:0]                   slot_sum;
  logic [WIW-1:0]                 push_slot;
  logic                           r1_kind;
  logic [bmq_pkg::TASK_W-1:0]     r1_task;
  logic [bmq_pkg::STATUS_W-1:0]   r1_status;
  logic [bmq_pkg::DATA_W-1:0]     r1_data;
  logic [bmq_pkg::DATA_W-1:0]     r2_data;

  // classify the latched request against the queue state
  always_comb begin
    is_recv    = (req_type_r == bmq_pkg::REQ_RECV);
    has_recv   = (wcount_r != '0) && (mode_r == bmq_pkg::MODE_RECV);
    has_send   = (wcount_r != '0) && (mode_r == bmq_pkg::MODE_SEND);
    ring_full  = (fill_r >= cap_r);
    ring_empty = (fill_r == '0);
    wl_full    = (wcount_r == WCW'(MAX_TASKS));
    do_pop     = (!is_recv && has_recv) || (is_recv && !ring_empty && has_send);
    do_ring_rd = is_recv && !ring_empty;
    send_store = !is_recv && !has_recv && !ring_full;
    do_ring_wr = send_store || (is_recv && !ring_empty && has_send);
    try_wait   = (!is_recv && !has_recv && ring_full) || (is_recv && ring_empty);
    do_push    = try_wait && may_wait_r && !wl_full;
    ring_wdata = is_recv ? pend_rd_r : msg_r;
  end

  // ring pointer wrap at capacity
  always_comb begin
    widx_inc = bmq_pkg::CAP_W'(widx_r) + 1'b1;
    ridx_inc = bmq_pkg::CAP_W'(ridx_r) + 1'b1;
  end

  // waiter slot for a push: head plus count, wrapped once
  always_comb begin
    slot_sum  = (WCW + 1)'(whead_r) + (WCW + 1)'(wcount_r);
    if (slot_sum >= (WCW + 1)'(MAX_TASKS)) begin
      slot_sum = slot_sum - (WCW + 1)'(MAX_TASKS);
    end
    push_slot = slot_sum[WIW-1:0];
  end

  // clamped capacity from a config write
  always_comb begin
    priority if (cfg_wdata == '0) begin
      cfg_cap = bmq_pkg::CAP_W'(1);
    end else if (cfg_wdata > CAP_MAX) begin
      cfg_cap = CAP_MAX;
    end else begin
      cfg_cap = cfg_wdata;
    end
  end

  // next control state
  always_comb begin
    widx_nxt   = widx_r;
    ridx_nxt   = ridx_r;
    fill_nxt   = fill_r;
    cap_nxt    = cap_r;
    mode_nxt   = mode_r;
    whead_nxt  = whead_r;
    wcount_nxt = wcount_r;
    priority if (cmd.commit) begin
      if (do_ring_wr) begin
        widx_nxt = (widx_inc >= cap_r) ? '0 : widx_inc[RIW-1:0];
      end
      if (do_ring_rd) begin
        ridx_nxt = (ridx_inc >= cap_r) ? '0 : ridx_inc[RIW-1:0];
      end
      fill_nxt   = fill_r + bmq_pkg::CAP_W'(do_ring_wr) - bmq_pkg::CAP_W'(do_ring_rd);
      wcount_nxt = wcount_r + WCW'(do_push) - WCW'(do_pop);
      if (do_pop) begin
        whead_nxt = (whead_r == WIW'(MAX_TASKS - 1)) ? '0 : whead_r + 1'b1;
      end
      priority if (do_push) begin
        mode_nxt = is_recv ? bmq_pkg::MODE_RECV : bmq_pkg::MODE_SEND;
      end else if (do_pop && wcount_r == WCW'(1)) begin
        mode_nxt = bmq_pkg::MODE_NONE;
      end else if (send_store) begin
        mode_nxt = bmq_pkg::MODE_NONE;
      end else begin
        mode_nxt = mode_r;
      end
    end else if (cfg_we && fill_r == '0) begin
      cap_nxt  = cfg_cap;
      widx_nxt = '0;
      ridx_nxt = '0;
    end else begin
      cap_nxt = cap_r;
    end
  end

  // first and second result words
  always_comb begin
    r1_kind   = do_pop ? bmq_pkg::KIND_WAKE : bmq_pkg::KIND_REPLY;
    r1_task   = do_pop ? wtask_rd_r : task_r;
    r1_status = bmq_pkg::STS_OK;
    if (!do_pop && try_wait) begin
      r1_status = do_push ? bmq_pkg::STS_WAIT : bmq_pkg::STS_FAIL;
    end
    priority if (do_pop) begin
      r1_data = is_recv ? '0 : bmq_pkg::DATA_W'(msg_r);
    end else if (do_ring_rd) begin
      r1_data = bmq_pkg::DATA_W'(ring_rd_r);
    end else begin
      r1_data = '0;
    end
    r2_data = is_recv ? bmq_pkg::DATA_W'(ring_rd_r) : '0;
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit || cmd.load2) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.two      = do_pop;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r      <= '0;
      ridx_r      <= '0;
      fill_r      <= '0;
      cap_r       <= CAP_INIT;
      mode_r      <= bmq_pkg::MODE_NONE;
      whead_r     <= '0;
      wcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      widx_r      <= widx_nxt;
      ridx_r      <= ridx_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      mode_r      <= mode_nxt;
      whead_r     <= whead_nxt;
      wcount_r    <= wcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request latch and memory reads at accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type_r <= in_req_type;
      task_r     <= in_task_id;
      msg_r      <= in_message[SW-1:0];
      may_wait_r <= in_may_wait;
      ring_rd_r  <= ring_mem[ridx_r];
      pend_rd_r  <= pend_mem[whead_r];
      wtask_rd_r <= wfifo_mem[whead_r];
    end
  end

  // ring write
  always_ff @(posedge clk) begin
    if (cmd.commit && do_ring_wr) begin
      ring_mem[widx_r] <= ring_wdata;
    end
  end

  // waiter list write
  always_ff @(posedge clk) begin
    if (cmd.commit && do_push) begin
      wfifo_mem[push_slot] <= task_r;
      pend_mem[push_slot]  <= is_recv ? '0 : msg_r;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    priority if (cmd.commit) begin
      out_kind_r   <= r1_kind;
      out_task_r   <= r1_task;
      out_status_r <= r1_status;
      out_data_r   <= r1_data;
      out_last_r   <= !do_pop;
    end else if (cmd.load2) begin
      out_kind_r   <= bmq_pkg::KIND_REPLY;
      out_task_r   <= task_r;
      out_status_r <= bmq_pkg::STS_OK;
      out_data_r   <= r2_data;
      out_last_r   <= 1'b1;
    end else begin
      out_kind_r   <= out_kind_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reply_kind  = out_kind_r;
  assign out_target_task = out_task_r;
  assign out_status      = out_status_r;
  assign out_data_word   = out_data_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  // an empty wait list always has no waiter kind
  a_mode_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (wcount_r == '0) |-> (mode_r == bmq_pkg::MODE_NONE))
    else $error("wait mode set with no waiters");

  // receivers only wait on an empty ring
  a_recv_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == bmq_pkg::MODE_RECV) |-> (fill_r == '0))
    else $error("receivers waiting while ring holds words");

  // senders only wait on a full ring
  a_send_full: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == bmq_pkg::MODE_SEND) |-> (fill_r == cap_r))
    else $error("senders waiting while ring has room");

  // counters stay in range
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= cap_r) && (wcount_r <= WCW'(MAX_TASKS)))
    else $error("fill or waiter count out of range");
`endif

endmodule

`default_nettype wire

/* src/blocking_message_queue.sv */
// top level of the blocking message queue (mailbox with blocking tasks)
// in_if carries one request word per handshake: send or receive, task id,
// message word and whether the task may wait. out_if returns result words:
// a reply to the requester, preceded by a wake-up of a waiting task when a
// send meets a waiting receiver or a receive frees a waiting sender; last
// marks the final word of a request. cfg_we/cfg_wdata set the ring capacity
// and are taken only while the ring is empty.
// The first result word is registered: the request and the ring and waiter
// memory reads are registered at accept, and in the execute state the
// decision loads the result register once that register is free. One
// request is in flight at a time; the result register lets the next
// request be accepted while a word waits.
// When out_if stalls, the controller holds in its execute or second-word
// state and in_if.ready stays low after the current request.
// Reset (rst_n low, synchronous) empties the ring and the wait list and sets
// capacity to 16 slots, or QUEUE_DEPTH if smaller. The memories are not
// cleared; the ring and waiter entries are used only after being written.
`default_nettype none

module blocking_message_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_TASKS   = 16,
  parameter int MSG_WIDTH   = 32
) (
  input  wire  logic                      clk,
  input  wire  logic                      rst_n,
  bmq_req_if.sink                         in_if,
  bmq_rsp_if.source                       out_if,
  input  wire  logic                      cfg_we,
  input  wire  logic [bmq_pkg::CAP_W-1:0] cfg_wdata
);

  bmq_pkg::bmq_cmd_t cmd;
  bmq_pkg::bmq_sts_t sts;
  logic              in_ready;

  // controller
  bmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  bmq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_TASKS   (MAX_TASKS),
    .MSG_WIDTH   (MSG_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_if.req_type),
    .in_task_id      (in_if.task_id),
    .in_message      (in_if.message),
    .in_may_wait     (in_if.may_wait),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_ready       (out_if.ready),
    .out_valid       (out_if.valid),
    .out_reply_kind  (out_if.reply_kind),
    .out_target_task (out_if.target_task),
    .out_status      (out_if.status),
    .out_data_word   (out_if.data_word),
    .out_last        (out_if.last)
  );

  assign in_if.ready = in_ready;

endmodule

`default_nettype wire
